// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication check failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");
`endif

// ----- src/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants of the strip cluster centroid finder.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    localparam logic [18:0] TOTAL_MAX = 19'h7FFFF;
    localparam logic [18:0] THR_RST   = 19'd50;
    localparam logic [7:0]  MW_RST    = 8'd90;

    localparam logic CFG_THR = 1'b0;
    localparam logic CFG_MW  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_SPLIT, S_ADDPREV, S_RST, S_PEAK, S_CUT, S_ADDCUR, S_CUTADD,
        S_FIN, S_LASTRST, S_END, S_EMIT, S_CLOSE, S_FLUSH, S_SQRT, S_DIVC,
        S_DIVEI, S_DIVE, S_RES
    } t_state;

    typedef struct packed {
        logic accept;
        logic clear_cl;
        logic restart;
        logic add_prev;
        logic add_cur;
        logic upd_peak;
        logic set_prev;
        logic clr_prev;
        logic close;
        logic load_out;
        logic out_last;
        logic sqrt_step;
        logic div_init_c;
        logic div_step;
        logic div_init_e;
        logic res_write;
    } t_cmd;

    typedef struct packed {
        logic prev_valid;
        logic adjacent;
        logic split;
        logic cut;
        logic last;
        logic qualify;
        logic pending;
        logic cnt_zero;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- src/scc_strip_if.sv -----
// ----------------------------------------------------------------------------
// scc_strip_if
// Fired-strip channel: valid/ready plus strip payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_strip_if #(
    parameter int CHANNEL_BITS = 10,
    parameter int CHARGE_BITS  = 12
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] strip_channel;
    logic [CHARGE_BITS-1:0]  strip_charge;
    logic                    side_last;

    modport source (output valid, strip_channel, strip_charge, side_last, input ready);
    modport sink   (input valid, strip_channel, strip_charge, side_last, output ready);
endinterface

`default_nettype wire

// ----- src/scc_clus_if.sv -----
// ----------------------------------------------------------------------------
// scc_clus_if
// Cluster result channel: valid/ready plus cluster payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface scc_clus_if #(
    parameter int CHANNEL_BITS = 10
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS+7:0] centroid;
    logic [16:0]             centroid_error;
    logic [18:0]             total_charge;
    logic [CHANNEL_BITS-1:0] first_channel;
    logic [8:0]              strip_count;
    logic                    run_last;

    modport source (output valid, centroid, centroid_error, total_charge,
                    first_channel, strip_count, run_last, input ready);
    modport sink   (input valid, centroid, centroid_error, total_charge,
                    first_channel, strip_count, run_last, output ready);
endinterface

`default_nettype wire

// ----- src/scc_ctrl.sv -----
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: walks one strip through the cluster steps, runs close jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  scc_pkg::t_status  i_st,
    output scc_pkg::t_cmd     o_cmd
);
    import scc_pkg::*;

    t_state r_state, n_state;
    t_state r_ret,   n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (!i_st.prev_valid) begin
                    o_cmd.clear_cl = 1'b1;
                    o_cmd.restart  = 1'b1;
                    n_state        = S_PEAK;
                end else if (i_st.adjacent && i_st.split) begin
                    n_ret   = S_ADDPREV;
                    n_state = S_CLOSE;
                end else if (i_st.adjacent) begin
                    n_state = S_PEAK;
                end else begin
                    n_ret   = S_RST;
                    n_state = S_CLOSE;
                end
            end
            S_ADDPREV: begin
                o_cmd.add_prev = 1'b1;
                o_cmd.restart  = 1'b1;
                n_state        = S_PEAK;
            end
            S_RST: begin
                o_cmd.restart = 1'b1;
                n_state       = S_PEAK;
            end
            S_PEAK: begin
                o_cmd.upd_peak = 1'b1;
                n_state        = S_CUT;
            end
            S_CUT: begin
                if (i_st.cut) begin
                    n_ret   = S_CUTADD;
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_ADDCUR;
                end
            end
            S_ADDCUR: begin
                o_cmd.add_cur = 1'b1;
                n_state       = S_FIN;
            end
            S_CUTADD: begin
                o_cmd.add_cur = 1'b1;
                o_cmd.restart = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                o_cmd.set_prev = 1'b1;
                if (i_st.last) begin
                    n_ret   = S_LASTRST;
                    n_state = S_CLOSE;
                end else begin
                    n_state = S_END;
                end
            end
            S_LASTRST: begin
                o_cmd.clr_prev = 1'b1;
                n_state        = S_END;
            end
            S_END: begin
                n_state = i_st.pending ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                if (i_st.qualify) begin
                    n_state = i_st.pending ? S_FLUSH : S_SQRT;
                end else begin
                    n_state = r_ret;
                end
            end
            S_FLUSH: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_st.cnt_zero) begin
                    o_cmd.div_init_c = 1'b1;
                    n_state          = S_DIVC;
                end
            end
            S_DIVC: begin
                o_cmd.div_step = 1'b1;
                if (i_st.cnt_zero) n_state = S_DIVEI;
            end
            S_DIVEI: begin
                o_cmd.div_init_e = 1'b1;
                n_state          = S_DIVE;
            end
            S_DIVE: begin
                o_cmd.div_step = 1'b1;
                if (i_st.cnt_zero) n_state = S_RES;
            end
            S_RES: begin
                o_cmd.res_write = 1'b1;
                n_state         = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/scc_dp.sv -----
// ----------------------------------------------------------------------------
// scc_dp
// Datapath: strip history, cluster sums, shared sqrt and divider, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_dp #(
    parameter int CHANNEL_BITS = 10,
    parameter int CHARGE_BITS  = 12
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire                     i_cfg_idx,
    input  wire  [18:0]             i_cfg_data,
    input  wire  [CHANNEL_BITS-1:0] i_ch,
    input  wire  [CHARGE_BITS-1:0]  i_q,
    input  wire                     i_last,
    input  scc_pkg::t_cmd           i_cmd,
    output scc_pkg::t_status        o_st,
    input  wire                     i_out_ready,
    output logic                    o_out_valid,
    output logic [CHANNEL_BITS+7:0] o_centroid,
    output logic [16:0]             o_error,
    output logic [18:0]             o_total,
    output logic [CHANNEL_BITS-1:0] o_first,
    output logic [8:0]              o_count,
    output logic                    o_run_last
);
    import scc_pkg::*;

    localparam int CB   = CHANNEL_BITS;
    localparam int QB   = CHARGE_BITS;
    localparam int DSW  = QB + 9;            // charge sum
    localparam int WW   = CB + QB + 9;       // weighted sum
    localparam int SSW  = 2 * QB + 9;        // square sum
    localparam int SQW  = 2 * QB + 42;       // sqrt radicand, even
    localparam int R    = SQW / 2;           // root bits
    localparam int DVW  = WW + 8;            // dividend / quotient
    localparam int CNTW = $clog2(DVW);
    localparam int KW   = CB + 10;
    localparam int CMW  = (DSW > 19) ? DSW : 19;

    logic [18:0]   r_thr;
    logic [7:0]    r_mw;
    logic          r_prev_valid, r_pending, r_o_valid;
    logic [1:0]    r_n;

    logic [CB-1:0] r_ch, r_prev_ch, r_start, r_first, r_job_first;
    logic [QB-1:0] r_q, r_prevq;
    logic          r_last;
    logic [QB:0]   r_peak;
    logic [DSW-1:0] r_sum, r_job_sum;
    logic [WW-1:0]  r_w, r_job_w;
    logic [SSW-1:0] r_sq;
    logic [8:0]     r_cnt, r_job_cnt;

    logic [SQW-1:0] r_x;
    logic [R+1:0]   r_rem;
    logic [R-1:0]   r_root;
    logic [DVW-1:0] r_dq;
    logic [DSW-1:0] r_drem;
    logic [CNTW-1:0] r_it;

    logic [CB+7:0] r_res_cent;
    logic [16:0]   r_res_err;
    logic [18:0]   r_res_tot;
    logic [CB-1:0] r_res_first;
    logic [8:0]    r_res_cnt;

    // strip selected for accumulation
    logic [CB-1:0]    a_ch;
    logic [QB-1:0]    a_q;
    logic [CB+QB-1:0] prod_w;
    logic [2*QB-1:0]  prod_sq;
    assign a_ch    = i_cmd.add_prev ? r_prev_ch : r_ch;
    assign a_q     = i_cmd.add_prev ? r_prevq   : r_q;
    assign prod_w  = (CB+QB)'(a_ch) * (CB+QB)'(a_q);
    assign prod_sq = (2*QB)'(a_q) * (2*QB)'(a_q);

    logic [QB:0] q_inc, prevq_inc;
    assign q_inc     = (QB+1)'(r_q) + (QB+1)'(1);
    assign prevq_inc = (QB+1)'(r_prevq) + (QB+1)'(1);

    logic signed [KW-1:0] width_sofar, mw_eff;
    assign width_sofar = $signed(KW'(r_prev_ch)) - $signed(KW'(r_start)) + $signed(KW'(1));
    assign mw_eff      = $signed(KW'((r_mw == 8'd0) ? 8'd1 : r_mw));

    // sqrt digit step
    logic [R+3:0] s_rs, s_trial;
    logic         s_ge;
    assign s_rs    = {r_rem, r_x[SQW-1 -: 2]};
    assign s_trial = (R+4)'({r_root, 2'b01});
    assign s_ge    = s_rs >= s_trial;

    // restoring divide step
    logic [DSW:0] d_rs, d_sub;
    logic         d_ge;
    assign d_rs  = {r_drem, r_dq[DVW-1]};
    assign d_sub = d_rs - {1'b0, r_job_sum};
    assign d_ge  = d_rs >= {1'b0, r_job_sum};

    logic out_free;
    assign out_free = !r_o_valid || i_out_ready;

    always_comb begin
        o_st.prev_valid = r_prev_valid;
        o_st.adjacent   = (CB+1)'(r_ch) == ((CB+1)'(r_prev_ch) + (CB+1)'(1));
        o_st.split      = (r_q > r_prevq) && (prevq_inc < r_peak) && (q_inc != r_peak);
        o_st.cut        = r_prev_valid && (width_sofar >= mw_eff);
        o_st.last       = r_last;
        o_st.qualify    = (r_cnt != 9'd0) && (CMW'(r_sum) > CMW'(r_thr)) && (r_n < 2'd2);
        o_st.pending    = r_pending;
        o_st.cnt_zero   = r_it == '0;
        o_st.out_free   = out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= THR_RST;
            r_mw         <= MW_RST;
            r_prev_valid <= 1'b0;
            r_pending    <= 1'b0;
            r_n          <= 2'd0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THR: r_thr <= i_cfg_data;
                    CFG_MW:  r_mw  <= i_cfg_data[7:0];
                endcase
            end
            if (i_cmd.accept)                     r_n <= 2'd0;
            else if (i_cmd.close && o_st.qualify) r_n <= r_n + 2'd1;
            if (i_cmd.set_prev)      r_prev_valid <= 1'b1;
            else if (i_cmd.clr_prev) r_prev_valid <= 1'b0;
            if (i_cmd.res_write)     r_pending <= 1'b1;
            else if (i_cmd.load_out) r_pending <= 1'b0;
            if (i_cmd.load_out)      r_o_valid <= 1'b1;
            else if (i_out_ready)    r_o_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch   <= i_ch;
            r_q    <= i_q;
            r_last <= i_last;
        end
        if (i_cmd.clear_cl || i_cmd.close) begin
            r_sum   <= '0;
            r_w     <= '0;
            r_sq    <= '0;
            r_cnt   <= '0;
            r_first <= '0;
        end
        if (i_cmd.add_prev || i_cmd.add_cur) begin
            if (r_cnt == 9'd0) r_first <= a_ch;
            r_cnt <= r_cnt + 9'd1;
            r_sum <= r_sum + DSW'(a_q);
            r_w   <= r_w + WW'(prod_w);
            r_sq  <= r_sq + SSW'(prod_sq);
        end
        if (i_cmd.restart) begin
            r_peak  <= '0;
            r_start <= r_ch;
        end
        if (i_cmd.upd_peak && (q_inc > r_peak)) r_peak <= q_inc;
        if (i_cmd.set_prev) begin
            r_prev_ch <= r_ch;
            r_prevq   <= r_q;
        end
        if (i_cmd.clr_prev) begin
            r_prev_ch <= '0;
            r_prevq   <= '0;
            r_start   <= '0;
            r_peak    <= '0;
        end
        if (i_cmd.close) begin
            r_job_sum   <= r_sum;
            r_job_w     <= r_w;
            r_job_first <= r_first;
            r_job_cnt   <= r_cnt;
            r_x         <= SQW'({r_sq, 32'd0});
            r_rem       <= '0;
            r_root      <= '0;
            r_it        <= CNTW'(R - 1);
        end
        // last sqrt digit also loads the centroid divide count
        if (i_cmd.sqrt_step) begin
            r_x    <= r_x << 2;
            r_rem  <= s_ge ? (R+2)'(s_rs - s_trial) : s_rs[R+1:0];
            r_root <= {r_root[R-2:0], s_ge};
            r_it   <= i_cmd.div_init_c ? CNTW'(DVW - 1) : r_it - CNTW'(1);
        end
        if (i_cmd.div_step) begin
            r_drem <= d_ge ? d_sub[DSW-1:0] : d_rs[DSW-1:0];
            r_dq   <= {r_dq[DVW-2:0], d_ge};
            r_it   <= r_it - CNTW'(1);
        end
        if (i_cmd.div_init_c) begin
            r_dq   <= {r_job_w, 8'd0};
            r_drem <= '0;
        end
        if (i_cmd.div_init_e) begin
            r_res_cent <= r_dq[CB+7:0];
            r_dq       <= DVW'(r_root);
            r_drem     <= '0;
            r_it       <= CNTW'(DVW - 1);
        end
        if (i_cmd.res_write) begin
            r_res_err   <= r_dq[16:0];
            r_res_tot   <= (CMW'(r_job_sum) > CMW'(TOTAL_MAX)) ? TOTAL_MAX : 19'(r_job_sum);
            r_res_first <= r_job_first;
            r_res_cnt   <= r_job_cnt;
        end
        if (i_cmd.load_out) begin
            o_centroid <= r_res_cent;
            o_error    <= r_res_err;
            o_total    <= r_res_tot;
            o_first    <= r_res_first;
            o_count    <= r_res_cnt;
            o_run_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_o_valid;

endmodule

`default_nettype wire

// ----- src/strip_cluster_centroid_finder_unit.sv -----
// ----------------------------------------------------------------------------
// strip_cluster_centroid_finder_unit
// Groups fired strips of one sensor side into clusters and reports the charge-weighted centroid,
// its error and cluster summary per cluster above the charge threshold, at most two per strip.
// ----------------------------------------------------------------------------
//  channel   dir  transfer carries
//  i_strip   in   strip_channel, strip_charge, side_last
//  o_clus    out  centroid, centroid_error, total_charge, first_channel,
//                 strip_count, run_last
//  i_cfg_*   in   register writes (0: charge_threshold, 1: max_width)
//
// Sequencing: a strip with no reported cluster passes only through the step
// sequencer. Each reported cluster also passes through the shared digit-serial
// sqrt (R = CHARGE_BITS+21 sqrt digits) and the single restoring divider
// (DVW = CHANNEL_BITS+CHARGE_BITS+17 divide steps).
// Reset: synchronous, active low; no memory, so no clearing pass.
// Stalls: the result register frees the back end once loaded; a second
// result or the final one waits only while the previous one is untaken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module strip_cluster_centroid_finder_unit #(
    parameter int CHANNEL_BITS = 10,
    parameter int CHARGE_BITS  = 12
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire  [18:0]  i_cfg_data,
    scc_strip_if.sink    i_strip,
    scc_clus_if.source   o_clus
);
    import scc_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    in_ready;

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_strip.valid),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    scc_dp #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .CHARGE_BITS  (CHARGE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_ch        (i_strip.strip_channel),
        .i_q         (i_strip.strip_charge),
        .i_last      (i_strip.side_last),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_out_ready (o_clus.ready),
        .o_out_valid (o_clus.valid),
        .o_centroid  (o_clus.centroid),
        .o_error     (o_clus.centroid_error),
        .o_total     (o_clus.total_charge),
        .o_first     (o_clus.first_channel),
        .o_count     (o_clus.strip_count),
        .o_run_last  (o_clus.run_last)
    );

    assign i_strip.ready = in_ready;

    // one strip in flight: no second transfer straight after the first
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_strip.valid && in_ready, !in_ready)
    // never overwrite a result still waiting on the output
    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, cmd.load_out, !o_clus.valid || o_clus.ready)
    // a finished result is held as pending until loaded out
    `ASSERT_NEXT(a_res_pending, i_clk, i_rst_n, cmd.res_write, st.pending)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for strip_cluster_centroid_finder_unit: strips are
// streamed in through the strip channel, mostly under random idling, each accepted
// transfer is run through a cluster predictor, and every cluster transfer
// leaving the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import scc_pkg::*;

    // one reported cluster as the output channel carries it
    typedef struct packed {
        logic [17:0] centroid;
        logic [16:0] centroid_error;
        logic [18:0] total_charge;
        logic [9:0]  first_channel;
        logic [8:0]  strip_count;
        logic        run_last;
    } cluster_t;

    // directed row: strip plus, where it is obvious, the single cluster it reports
    typedef struct {
        logic [9:0]  ch;
        logic [11:0] q;
        logic        last;
        bit          typed;
        cluster_t    res;
    } strip_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [18:0] i_cfg_data;

    scc_strip_if #(.CHANNEL_BITS(10), .CHARGE_BITS(12)) strip_ch ();
    scc_clus_if  #(.CHANNEL_BITS(10))                   clus_ch ();

    strip_cluster_centroid_finder_unit #(
        .CHANNEL_BITS(10),
        .CHARGE_BITS (12)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_strip   (strip_ch.sink),
        .o_clus    (clus_ch.source)
    );

    cluster_t    pending_clusters[$];   // predicted clusters not yet seen
    int          err_count;
    int          strips_sent;
    int          clusters_seen;
    bit          idling_on;             // both sides idle at random when set

    // predictor copy of the block's registers and cluster state
    logic [18:0] thr_reg;
    logic [7:0]  mw_reg;
    bit          pv;
    logic [9:0]  p_ch;
    logic [11:0] p_q;
    logic [9:0]  start_ch;
    logic [12:0] peak_p1;               // peak + 1, 0 when none seen
    logic [31:0] q_sum;
    logic [63:0] w_sum;
    logic [63:0] sq_sum;
    logic [9:0]  c_first;
    logic [8:0]  c_count;
    cluster_t    step_res[2];
    int          step_n;

    // clock: 10 ns
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard limit well beyond the slowest legal run
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // largest e in [0,65536] with (e*sum)^2 <= sq * 2^32
    function automatic logic [16:0] err_q16(logic [63:0] sq, logic [31:0] sum);
        logic [127:0] lim;
        logic [127:0] t;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        lim = {64'd0, sq} << 32;
        lo  = 0;
        hi  = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 128'(mid) * 128'(sum);
            if (t * t <= lim) lo = mid;
            else hi = mid - 1;
        end
        return 17'(lo);
    endfunction

    function automatic void clear_clus();
        q_sum   = 0;
        w_sum   = 0;
        sq_sum  = 0;
        c_first = 0;
        c_count = 0;
    endfunction

    function automatic void add_strip(logic [9:0] ch, logic [11:0] q);
        if (c_count == 0) c_first = ch;
        c_count = c_count + 1'b1;
        q_sum   = q_sum + q;
        w_sum   = w_sum + 64'(ch) * 64'(q);
        sq_sum  = sq_sum + 64'(q) * 64'(q);
    endfunction

    // report the open cluster if it carries enough charge and fewer than two came from this strip, then empty it
    function automatic void close_clus();
        logic [63:0] c;
        if (c_count != 0 && q_sum > 32'(thr_reg) && step_n < 2) begin
            c = (w_sum << 8) / 64'(q_sum);
            step_res[step_n].centroid       = c[17:0];
            step_res[step_n].centroid_error = err_q16(sq_sum, q_sum);
            step_res[step_n].total_charge   = (q_sum > 32'(TOTAL_MAX)) ?
                                              TOTAL_MAX : q_sum[18:0];
            step_res[step_n].first_channel  = c_first;
            step_res[step_n].strip_count    = c_count;
            step_res[step_n].run_last       = 1'b0;
            step_n++;
        end
        clear_clus();
    endfunction

    // clusters closed by one accepted strip land in step_res[0..step_n-1]
    function automatic void cluster_strip(logic [9:0] ch, logic [11:0] q, logic last);
        int mw;
        mw     = (mw_reg == 0) ? 1 : int'(mw_reg);
        step_n = 0;
        if (!pv) begin
            clear_clus();
            peak_p1  = 0;
            start_ch = ch;
        end else if (ch == p_ch + 10'd1 && p_ch != 10'h3FF) begin
            // rise after a local minimum below the peak: the minimum is shared
            if (q > p_q && 13'(p_q) + 13'd1 < peak_p1 && 13'(q) + 13'd1 != peak_p1) begin
                close_clus();
                add_strip(p_ch, p_q);
                peak_p1  = 0;
                start_ch = ch;
            end
        end else begin
            close_clus();
            peak_p1  = 0;
            start_ch = ch;
        end
        if (13'(q) + 13'd1 > peak_p1) peak_p1 = 13'(q) + 13'd1;
        if (pv && int'(p_ch) - int'(start_ch) + 1 >= mw) begin
            close_clus();
            add_strip(ch, q);
            peak_p1  = 0;
            start_ch = ch;
        end else begin
            add_strip(ch, q);
        end
        pv   = 1'b1;
        p_ch = ch;
        p_q  = q;
        if (last) begin
            close_clus();
            pv       = 1'b0;
            p_ch     = 0;
            p_q      = 0;
            start_ch = 0;
            peak_p1  = 0;
        end
        if (step_n > 0) step_res[step_n-1].run_last = 1'b1;
    endfunction

    // one strip transfer; typed rows queue their own expectation
    task automatic send_strip(logic [9:0] ch, logic [11:0] q, logic last,
                              bit typed = 0, cluster_t res = '0);
        if (idling_on && $urandom_range(99) < 35) begin
            strip_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 35);
        end
        strip_ch.valid         <= 1'b1;
        strip_ch.strip_channel <= ch;
        strip_ch.strip_charge  <= q;
        strip_ch.side_last     <= last;
        do @(posedge i_clk); while (!strip_ch.ready);
        cluster_strip(ch, q, last);
        if (typed) begin
            pending_clusters.push_back(res);
        end else begin
            for (int k = 0; k < step_n; k++) pending_clusters.push_back(step_res[k]);
        end
        strips_sent++;
    endtask

    // drop valid and wait for the back end to drain, plus the step sequencer
    task automatic drain();
        strip_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_clusters.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // one write cycle, then the enable drops and the predictor copy follows
    task automatic write_reg(logic idx, logic [18:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_THR) thr_reg = data;
        else mw_reg = data[7:0];
        @(posedge i_clk);
    endtask

    // one sensor side of mostly adjacent strips with a random charge profile
    task automatic send_side(bit longside);
        int          len;
        int unsigned base;
        logic [9:0]  ch;
        logic [11:0] q;
        len  = longside ? $urandom_range(260, 40) : $urandom_range(10, 1);
        base = $urandom_range(1023);
        if (base + len > 1023 && $urandom_range(3) != 0) base = 1023 - len;
        ch = 10'(base);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(7))
                0:       q = 12'($urandom_range(4095));
                1:       q = 12'($urandom_range(60));
                2:       q = 12'hFFF;
                default: q = 12'($urandom_range(800, 20));
            endcase
            if ($urandom_range(19) == 0) ch = 10'($urandom_range(1023));  // broken order
            send_strip(ch, q, (k == len - 1) ? 1'b1 : 1'b0);
            ch = ch + (($urandom_range(9) == 0) ? 10'($urandom_range(4, 2)) : 10'd1);
        end
    endtask

    // result side: random back-pressure, compare each transfer with the oldest prediction
    initial begin
        cluster_t got;
        cluster_t want;
        clus_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && clus_ch.valid && clus_ch.ready) begin
                got = '{clus_ch.centroid, clus_ch.centroid_error, clus_ch.total_charge,
                        clus_ch.first_channel, clus_ch.strip_count, clus_ch.run_last};
                clusters_seen++;
                if (pending_clusters.size() == 0) begin
                    $display("%0t: unexpected cluster %p", $time, got);
                    err_count++;
                end else begin
                    want = pending_clusters.pop_front();
                    if (got.centroid != want.centroid) begin
                        $display("%0t: centroid exp %0d got %0d", $time,
                                 want.centroid, got.centroid);
                        err_count++;
                    end
                    if (got.centroid_error != want.centroid_error) begin
                        $display("%0t: centroid_error exp %0d got %0d", $time,
                                 want.centroid_error, got.centroid_error);
                        err_count++;
                    end
                    if (got.total_charge != want.total_charge) begin
                        $display("%0t: total_charge exp %0d got %0d", $time,
                                 want.total_charge, got.total_charge);
                        err_count++;
                    end
                    if (got.first_channel != want.first_channel) begin
                        $display("%0t: first_channel exp %0d got %0d", $time,
                                 want.first_channel, got.first_channel);
                        err_count++;
                    end
                    if (got.strip_count != want.strip_count) begin
                        $display("%0t: strip_count exp %0d got %0d", $time,
                                 want.strip_count, got.strip_count);
                        err_count++;
                    end
                    if (got.run_last != want.run_last) begin
                        $display("%0t: run_last exp %0d got %0d", $time,
                                 want.run_last, got.run_last);
                        err_count++;
                    end
                end
            end
            clus_ch.ready <= !(idling_on && $urandom_range(99) < 35);
        end
    end

    // stimulus
    initial begin
        strip_row_t rows[$];
        logic [18:0] thr_set[7];
        logic [7:0]  mw_set[7];
        err_count     = 0;
        strips_sent   = 0;
        clusters_seen = 0;
        idling_on     = 1'b1;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_THR;
        i_cfg_data    = '0;
        strip_ch.valid         = 1'b0;
        strip_ch.strip_channel = '0;
        strip_ch.strip_charge  = '0;
        strip_ch.side_last     = 1'b0;
        thr_reg  = THR_RST;
        mw_reg   = MW_RST;
        pv       = 1'b0;
        p_ch     = 0;
        p_q      = 0;
        start_ch = 0;
        peak_p1  = 0;
        clear_clus();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset settings (threshold 50, cut width 90)
        // single full-scale strips at both channel extremes
        rows.push_back('{10'd0,    12'hFFF, 1'b1, 1, '{18'd0, 17'd65536, 19'd4095,
                                                     10'd0, 9'd1, 1'b1}});
        rows.push_back('{10'd1023, 12'hFFF, 1'b1, 1, '{18'd261888, 17'd65536, 19'd4095,
                                                     10'd1023, 9'd1, 1'b1}});
        // empty cluster, one at threshold, one just above
        rows.push_back('{10'd5, 12'd0,  1'b1, 0, '0});
        rows.push_back('{10'd5, 12'd50, 1'b1, 0, '0});
        rows.push_back('{10'd5, 12'd51, 1'b1, 1, '{18'd1280, 17'd65536, 19'd51,
                                                 10'd5, 9'd1, 1'b1}});
        // rise after a minimum back to exactly the peak: one cluster, no split
        rows.push_back('{10'd10, 12'd100, 1'b0, 0, '0});
        rows.push_back('{10'd11, 12'd20,  1'b0, 0, '0});
        rows.push_back('{10'd12, 12'd100, 1'b1, 0, '0});
        // rise to exactly the peak does not split; a later rise does
        rows.push_back('{10'd50, 12'd100, 1'b0, 0, '0});
        rows.push_back('{10'd51, 12'd20,  1'b0, 0, '0});
        rows.push_back('{10'd52, 12'd100, 1'b0, 0, '0});
        rows.push_back('{10'd53, 12'd90,  1'b0, 0, '0});
        rows.push_back('{10'd54, 12'd300, 1'b1, 0, '0});
        // channel gap, repeated channel, channel going down
        rows.push_back('{10'd20, 12'd200, 1'b0, 0, '0});
        rows.push_back('{10'd25, 12'd200, 1'b0, 0, '0});
        rows.push_back('{10'd25, 12'd200, 1'b0, 0, '0});
        rows.push_back('{10'd22, 12'd60,  1'b1, 0, '0});
        // adjacent wide strips across the top channel
        rows.push_back('{10'd1022, 12'hFFF, 1'b0, 0, '0});
        rows.push_back('{10'd1023, 12'hAAA, 1'b0, 0, '0});
        rows.push_back('{10'd0,    12'h555, 1'b1, 0, '0});
        foreach (rows[i]) send_strip(rows[i].ch, rows[i].q, rows[i].last,
                                     rows[i].typed, rows[i].res);

        // the sender holds off until every cluster has come back
        drain();

        // random part: seven register settings, reset values first, then extremes; zero cut width acts as one
        thr_set = '{19'd50, 19'd0, 19'h7FFFF, 19'd0, 19'd300, 19'd1000, 19'd20};
        mw_set  = '{8'd90,  8'd1,  8'd255,    8'd0,  8'd3,    8'd255,   8'd5};
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_THR, (p == 6) ? 19'($urandom_range(200)) : thr_set[p]);
            write_reg(CFG_MW,  mw_set[p]);
            idling_on = (p != 4);          // one phase with no idling at all
            while (strips_sent < 20 + (p + 1) * 200)
                send_side($urandom_range(24) == 0);
            drain();
        end
        idling_on = 1'b1;

        repeat (200) @(posedge i_clk);
        $display("Covered %0d strips and %0d clusters over seven register settings,",
                 strips_sent, clusters_seen);
        $display("with splits, gaps, width cuts and idling on both channels.");
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/scc_pkg.sv
src/scc_strip_if.sv
src/scc_clus_if.sv
src/scc_ctrl.sv
src/scc_dp.sv
src/strip_cluster_centroid_finder_unit.sv
tb/testbench.sv
